// ===== hdl/olad_pkg.sv =====
// Shared constants and types for the ordered list block.
`timescale 1ns / 1ps

package olad_pkg;

    localparam int CAPACITY  = 16;
    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 2;
    localparam int POS_W     = 4;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 5;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

    // operation codes
    localparam logic [FUNC_W-1:0] OP_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] OP_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] OP_READ   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

    // per-cell command from the list control
    typedef struct packed {
        logic wr;     // load the key into this cell
        logic del;    // delete in progress
        logic valid;  // cell holds a live entry
        logic sel;    // cell is the read position
    } cell_ctl_t;

    // carried from one cell to the next, head toward tail
    typedef struct packed {
        logic              hit;  // a match at or before this cell
        logic [DATA_W-1:0] rd;   // read data picked up so far
    } cell_link_t;

endpackage

// ===== hdl/olad_if.sv =====
// Valid/ready channel interfaces for the ordered list block.
`timescale 1ns / 1ps

interface olad_req_if;
    logic                                valid;
    logic                                ready;
    logic [olad_pkg::FUNC_W-1:0]         func;
    logic signed [olad_pkg::DATA_W-1:0]  value;
    logic [olad_pkg::POS_W-1:0]          position;

    modport source (output valid, func, value, position, input ready);
    modport sink   (input valid, func, value, position, output ready);
endinterface

interface olad_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [olad_pkg::STATUS_W-1:0]       status;
    logic signed [olad_pkg::DATA_W-1:0]  read_value;
    logic [olad_pkg::COUNT_W-1:0]        entry_count;

    modport source (output valid, status, read_value, entry_count, input ready);
    modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

// ===== hdl/olad_cell.sv =====
// One list cell: holds an entry, compares it with the key, shifts on delete.
`timescale 1ns / 1ps

module olad_cell
(
    input  logic                         clk,
    input  olad_pkg::cell_ctl_t          ctl,
    input  logic [olad_pkg::DATA_W-1:0]  key,
    input  logic [olad_pkg::DATA_W-1:0]  next_value,
    input  olad_pkg::cell_link_t         link_in,
    output olad_pkg::cell_link_t         link_out,
    output logic [olad_pkg::DATA_W-1:0]  value
);

    logic [olad_pkg::DATA_W-1:0] value_reg;
    logic [olad_pkg::DATA_W-1:0] value_next;
    logic                        match;
    logic                        at_or_after_hit;

    assign match           = ctl.valid && (value_reg == key);
    assign at_or_after_hit = link_in.hit || match;

    assign link_out.hit = at_or_after_hit;
    assign link_out.rd  = ctl.sel ? value_reg : link_in.rd;
    assign value        = value_reg;

    always_comb
    begin
        priority if (ctl.wr)
        begin
            value_next = key;
        end
        else if (ctl.del && at_or_after_hit)
        begin
            // close the gap: take the neighbor toward the tail
            value_next = next_value;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== hdl/ordered_list_append_delete.sv =====
// Top level: ordered list kept in a chain of cells, with an output register.
`timescale 1ns / 1ps
//
//  channel | dir | beat contents                        | accepted when
//  --------+-----+--------------------------------------+--------------------------
//  req     | in  | func, value, position                | req.valid && req.ready
//  rsp     | out | status, read_value, entry_count      | rsp.valid && rsp.ready
//
//  A req beat is applied to all cells at the clock edge that accepts it and its rsp
//  beat is valid on the next cycle. Throughput is one beat per cycle while rsp is not
//  stalled, set by the compare/shift across the cell chain at the accepting edge.
//  req.ready is high whenever the output register is empty or being drained, so a
//  stalled rsp holds the one finished result and blocks only further req beats.
//  Reset empties the list (count to zero) and drops any pending result; cell contents
//  are not cleared, as entries beyond the count are never read.

module ordered_list_append_delete
(
    input  logic              clk,
    input  logic              rst_n,
    olad_req_if.sink          req,
    olad_rsp_if.source        rsp
);

    localparam int N = olad_pkg::CAPACITY;

    // list length
    logic [olad_pkg::CNT_W-1:0]    count_reg;
    logic [olad_pkg::CNT_W-1:0]    count_next;

    // output register
    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;
    logic [olad_pkg::STATUS_W-1:0] status_reg;
    logic [olad_pkg::STATUS_W-1:0] status_next;
    logic [olad_pkg::DATA_W-1:0]   rdata_reg;
    logic [olad_pkg::DATA_W-1:0]   rdata_next;
    logic [olad_pkg::COUNT_W-1:0]  ecount_reg;

    logic                          accept;
    logic                          is_full;
    logic                          is_empty;
    logic                          pos_ok;
    logic                          found;
    logic                          do_append;
    logic                          do_delete;
    logic [olad_pkg::CMP_W-1:0]    count_cmp;
    logic [olad_pkg::CMP_W-1:0]    pos_cmp;
    logic [olad_pkg::DATA_W-1:0]   key;

    olad_pkg::cell_ctl_t           ctl  [N];
    olad_pkg::cell_link_t          link [N+1];
    logic [olad_pkg::DATA_W-1:0]   cell_value [N];

    // a new beat is taken whenever the result register frees up this cycle
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign key       = req.value;
    assign count_cmp = olad_pkg::CMP_W'(count_reg);
    assign pos_cmp   = olad_pkg::CMP_W'(req.position);
    assign is_full   = (count_reg == olad_pkg::CNT_W'(N));
    assign is_empty  = (count_reg == '0);
    assign pos_ok    = (pos_cmp < count_cmp);

    assign do_append = accept && (req.func == olad_pkg::OP_APPEND) && !is_full;
    assign do_delete = accept && (req.func == olad_pkg::OP_DELETE);

    // head of the chain: no match yet, no read data
    assign link[0].hit = 1'b0;
    assign link[0].rd  = '0;
    assign found       = link[N].hit;

    // ---------------------------------------------------------------------
    // Cell chain: cell 0 is the head. A delete shifts every cell at or past
    // the first match; with no match nothing moves.
    // ---------------------------------------------------------------------
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        assign ctl[i].valid = (olad_pkg::CMP_W'(i) < count_cmp);
        assign ctl[i].sel   = (olad_pkg::CMP_W'(i) == pos_cmp);
        assign ctl[i].wr    = do_append && (olad_pkg::CMP_W'(i) == count_cmp);
        assign ctl[i].del   = do_delete;

        if (i == N - 1)
        begin : g_tail
            olad_cell u_cell
            (
                .clk        (clk),
                .ctl        (ctl[i]),
                .key        (key),
                .next_value (cell_value[i]),
                .link_in    (link[i]),
                .link_out   (link[i+1]),
                .value      (cell_value[i])
            );
        end
        else
        begin : g_body
            olad_cell u_cell
            (
                .clk        (clk),
                .ctl        (ctl[i]),
                .key        (key),
                .next_value (cell_value[i+1]),
                .link_in    (link[i]),
                .link_out   (link[i+1]),
                .value      (cell_value[i])
            );
        end
    end

    // ---------------------------------------------------------------------
    // Operation decode: status, read data and new length
    // ---------------------------------------------------------------------
    always_comb
    begin
        status_next = olad_pkg::ST_OK;
        rdata_next  = '0;
        count_next  = count_reg;
        unique case (req.func)
            olad_pkg::OP_APPEND:
            begin
                if (is_full)
                begin
                    status_next = olad_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + olad_pkg::CNT_W'(1);
                end
            end
            olad_pkg::OP_DELETE:
            begin
                priority if (is_empty)
                begin
                    status_next = olad_pkg::ST_EMPTY;
                end
                else if (!found)
                begin
                    status_next = olad_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    count_next = count_reg - olad_pkg::CNT_W'(1);
                end
            end
            olad_pkg::OP_READ:
            begin
                priority if (is_empty)
                begin
                    status_next = olad_pkg::ST_EMPTY;
                end
                else if (!pos_ok)
                begin
                    status_next = olad_pkg::ST_RANGE;
                end
                else
                begin
                    rdata_next = link[N].rd;
                end
            end
            default:
            begin
                // unused code: no change, ok status
                status_next = olad_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        priority if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            rdata_reg  <= rdata_next;
            ecount_reg <= olad_pkg::COUNT_W'(count_next);
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.read_value  = rdata_reg;
    assign rsp.entry_count = ecount_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= olad_pkg::CNT_W'(N))
        else $error("list length above capacity");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.func == olad_pkg::OP_APPEND && !is_full)
        |=> count_reg == $past(count_reg) + olad_pkg::CNT_W'(1))
        else $error("append did not grow the list");

    a_rsp_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp.valid && rsp.entry_count == olad_pkg::COUNT_W'(count_reg))
        else $error("reported count differs from list length");

    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != olad_pkg::ST_OK) |-> rsp.read_value == '0)
        else $error("read data nonzero on failed operation");

endmodule
